FILE: design/cdig_pkg.sv
// ----------------------------------------------------------------------------
// cdig_pkg: shared types and constants of the image gradient block
// Field widths, configuration register codes, result slot codes and the
// difference helpers used by the gradient datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cdig_pkg;

    // field widths
    localparam int SAMPLE_W    = 16;
    localparam int GRAD_W      = SAMPLE_W + 2;
    localparam int ROW_POS_W   = 12;
    localparam int COL_POS_W   = 10;
    localparam int ROW_COUNT_W = 13;
    localparam int COL_COUNT_W = 11;
    localparam int CFG_DATA_W  = 13;
    localparam int OUT_TDATA_W = 64;

    // configuration register indexes
    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_COL_COUNT = 1'b1;

    // result slots of one input sample, in delivery order
    localparam logic [1:0] RES_PREV_ROW = 2'd0;
    localparam logic [1:0] RES_LAST_ROW = 2'd1;
    localparam logic [1:0] RES_FINAL    = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [GRAD_W-1:0]   t_grad;

    // one accepted sample with its precomputed position flags
    typedef struct packed {
        t_sample                sample;
        logic [ROW_POS_W-1:0]   row_pos_up;
        logic [ROW_POS_W-1:0]   row_pos;
        logic [COL_POS_W-1:0]   col_pos;
        logic [COL_POS_W-1:0]   col_pos_left;
        logic                   has_out;
        logic                   row_second;
        logic                   row_last;
        logic                   col_first;
        logic                   col_second;
        logic                   col_last;
        logic                   bank;
    } t_stage;

    // neighborhood of the current sample from the line stores and history
    typedef struct packed {
        t_sample cur_here;
        t_sample prv_here;
        t_sample prv_next;
        t_sample prv_left;
        t_sample cur_left;
        t_sample cur_left2;
    } t_nbr;

    // one result item
    typedef struct packed {
        t_grad                grad_outer;
        t_grad                grad_inner;
        logic [ROW_POS_W-1:0] row_pos;
        logic [COL_POS_W-1:0] col_pos;
        logic                 last_of_run;
        logic                 frame_done;
    } t_result;

    // central difference, already in half units
    function automatic t_grad grad_half(input t_sample a, input t_sample b);
        logic [SAMPLE_W:0] d;
        d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
        return {d[SAMPLE_W], d};
    endfunction

    // one-sided difference, doubled into half units
    function automatic t_grad grad_full(input t_sample a, input t_sample b);
        logic [SAMPLE_W:0] d;
        d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
        return {d, 1'b0};
    endfunction

endpackage

`default_nettype wire

FILE: design/cdig_ram.sv
// ----------------------------------------------------------------------------
// cdig_ram: generic line store
// One write port and two read ports, read data registered and held
// between read enables; a read of the address being written returns the
// old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module cdig_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic      [WIDTH-1:0]         o_rd_data_a,
    output logic      [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

endmodule

`default_nettype wire

FILE: design/cdig_grad.sv
// ----------------------------------------------------------------------------
// cdig_grad: gradient datapath
// Forms the up to three results of one sample from its neighborhood:
// the previous row's result at this column, the last row's result one
// column back, and the final sample's result.
// ----------------------------------------------------------------------------
`default_nettype none

module cdig_grad (
    input  wire cdig_pkg::t_stage       i_stage,
    input  wire cdig_pkg::t_nbr         i_nbr,
    output cdig_pkg::t_result [2:0]     o_res
);

    always_comb begin
        o_res = '0;

        // previous row at this column
        if (i_stage.row_second) begin
            o_res[cdig_pkg::RES_PREV_ROW].grad_outer =
                cdig_pkg::grad_full(i_stage.sample, i_nbr.prv_here);
        end else begin
            o_res[cdig_pkg::RES_PREV_ROW].grad_outer =
                cdig_pkg::grad_half(i_stage.sample, i_nbr.cur_here);
        end
        if (i_stage.col_first) begin
            o_res[cdig_pkg::RES_PREV_ROW].grad_inner =
                cdig_pkg::grad_full(i_nbr.prv_next, i_nbr.prv_here);
        end else if (i_stage.col_last) begin
            o_res[cdig_pkg::RES_PREV_ROW].grad_inner =
                cdig_pkg::grad_full(i_nbr.prv_here, i_nbr.prv_left);
        end else begin
            o_res[cdig_pkg::RES_PREV_ROW].grad_inner =
                cdig_pkg::grad_half(i_nbr.prv_next, i_nbr.prv_left);
        end
        o_res[cdig_pkg::RES_PREV_ROW].row_pos     = i_stage.row_pos_up;
        o_res[cdig_pkg::RES_PREV_ROW].col_pos     = i_stage.col_pos;
        o_res[cdig_pkg::RES_PREV_ROW].last_of_run =
            !(i_stage.row_last && !i_stage.col_first);
        o_res[cdig_pkg::RES_PREV_ROW].frame_done  = 1'b0;

        // last row, one column back
        o_res[cdig_pkg::RES_LAST_ROW].grad_outer =
            cdig_pkg::grad_full(i_nbr.cur_left, i_nbr.prv_left);
        if (i_stage.col_second) begin
            o_res[cdig_pkg::RES_LAST_ROW].grad_inner =
                cdig_pkg::grad_full(i_stage.sample, i_nbr.cur_left);
        end else begin
            o_res[cdig_pkg::RES_LAST_ROW].grad_inner =
                cdig_pkg::grad_half(i_stage.sample, i_nbr.cur_left2);
        end
        o_res[cdig_pkg::RES_LAST_ROW].row_pos     = i_stage.row_pos;
        o_res[cdig_pkg::RES_LAST_ROW].col_pos     = i_stage.col_pos_left;
        o_res[cdig_pkg::RES_LAST_ROW].last_of_run = !i_stage.col_last;
        o_res[cdig_pkg::RES_LAST_ROW].frame_done  = 1'b0;

        // final sample of the frame
        o_res[cdig_pkg::RES_FINAL].grad_outer =
            cdig_pkg::grad_full(i_stage.sample, i_nbr.prv_here);
        o_res[cdig_pkg::RES_FINAL].grad_inner =
            cdig_pkg::grad_full(i_stage.sample, i_nbr.cur_left);
        o_res[cdig_pkg::RES_FINAL].row_pos     = i_stage.row_pos;
        o_res[cdig_pkg::RES_FINAL].col_pos     = i_stage.col_pos;
        o_res[cdig_pkg::RES_FINAL].last_of_run = 1'b1;
        o_res[cdig_pkg::RES_FINAL].frame_done  = 1'b1;
    end

endmodule

`default_nettype wire

FILE: design/central_difference_image_gradient.sv
// ----------------------------------------------------------------------------
// central_difference_image_gradient: streaming image gradient
// Outer and inner central-difference gradients of a raster of samples,
// one-sided at the borders, in half units.
// ----------------------------------------------------------------------------
// The block takes one sample per clock in row-major order and returns, for
// every sample, the gradient along rows and along columns in half units.
// Results for a row come out while the next row streams in, the sample that
// completes them passing the input register and the output register; in the
// last row each sample after the first yields two results (three on the final
// sample) and, as the output gives one result per cycle while the result side
// is ready, the input is held off until they are out. Elsewhere the rate is one
// sample per cycle unless the result side stalls, set by the single input
// register, the gradient logic and the output register. Two line stores of MAX_COLS
// samples (one write and two reads per cycle) hold the current and previous rows.
// A write to either size register restarts the frame; stored lines are kept.
`default_nettype none

module central_difference_image_gradient #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_index,
    input  wire logic [cdig_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // sample stream
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [15:0]                       i_s_axis_tdata,  // sample[15:0]
    // result stream
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // grad_outer[17:0], grad_inner[35:18], row_pos[47:36], col_pos[57:48], zeros
    output logic [cdig_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    output logic                                   o_m_axis_tlast,  // last_of_run
    output logic                                   o_m_axis_tuser   // frame_done
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int PAD_W = cdig_pkg::OUT_TDATA_W - 2 * cdig_pkg::GRAD_W
                           - cdig_pkg::ROW_POS_W - cdig_pkg::COL_POS_W;

    // size registers, held as last index
    logic [ROW_W-1:0] r_row_last, n_row_last;
    logic [COL_W-1:0] r_col_last, n_col_last;
    logic [31:0]      w_row_lim, w_col_lim;

    // raster position of the next sample
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic             r_bank;
    logic [COL_W-1:0] w_col_next_addr;

    // input stage
    logic               r_st_valid;
    cdig_pkg::t_stage   r_stage, n_stage;
    cdig_pkg::t_sample  r_prv_left, r_cur_left, r_cur_left2;
    logic [1:0]         r_res_sel;
    logic [31:0]        w_row32, w_col32, w_row_up32, w_col_left32;

    // line store ports
    logic [15:0]        w_a_rd_a, w_a_rd_b, w_b_rd_a, w_b_rd_b;
    cdig_pkg::t_nbr     w_nbr;

    // result selection and output register
    cdig_pkg::t_result [2:0] w_res_all;
    cdig_pkg::t_result       w_res;
    cdig_pkg::t_result       r_out;
    logic                    r_out_valid;
    logic                    w_out_load_ok;
    logic                    w_issue;
    logic                    w_st_done;
    logic                    w_accept;

    // handshake
    assign w_out_load_ok   = !r_out_valid || i_m_axis_tready;
    assign w_issue         = r_st_valid && r_stage.has_out && w_out_load_ok;
    assign w_st_done       = r_st_valid
                             && (!r_stage.has_out || (w_out_load_ok && w_res.last_of_run));
    assign o_s_axis_tready = !r_st_valid || w_st_done;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // size clamping of configuration writes
    always_comb begin
        if (i_cfg_data < cdig_pkg::CFG_DATA_W'(2)) begin
            w_row_lim = 32'd1;
        end else if (32'(i_cfg_data) > 32'(MAX_ROWS)) begin
            w_row_lim = 32'(MAX_ROWS - 1);
        end else begin
            w_row_lim = 32'(i_cfg_data) - 32'd1;
        end
        if (i_cfg_data[cdig_pkg::COL_COUNT_W-1:0] < cdig_pkg::COL_COUNT_W'(2)) begin
            w_col_lim = 32'd1;
        end else if (32'(i_cfg_data[cdig_pkg::COL_COUNT_W-1:0]) > 32'(MAX_COLS)) begin
            w_col_lim = 32'(MAX_COLS - 1);
        end else begin
            w_col_lim = 32'(i_cfg_data[cdig_pkg::COL_COUNT_W-1:0]) - 32'd1;
        end
        n_row_last = r_row_last;
        n_col_last = r_col_last;
        if (i_cfg_we) begin
            case (i_cfg_index)
                cdig_pkg::CFG_ROW_COUNT: n_row_last = w_row_lim[ROW_W-1:0];
                cdig_pkg::CFG_COL_COUNT: n_col_last = w_col_lim[COL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_last <= ROW_W'(1);
            r_col_last <= COL_W'(1);
        end else begin
            r_row_last <= n_row_last;
            r_col_last <= n_col_last;
        end
    end

    // raster counters and bank select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_bank <= 1'b0;
        end else if (i_cfg_we) begin
            r_row  <= '0;
            r_col  <= '0;
            r_bank <= 1'b0;
        end else if (w_accept) begin
            if (r_col == r_col_last) begin
                r_col <= '0;
                if (r_row == r_row_last) begin
                    r_row  <= '0;
                    r_bank <= 1'b0;
                end else begin
                    r_row  <= r_row + ROW_W'(1);
                    r_bank <= !r_bank;
                end
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // position fields and flags of the incoming sample
    assign w_row32      = 32'(r_row);
    assign w_col32      = 32'(r_col);
    assign w_row_up32   = w_row32 - 32'd1;
    assign w_col_left32 = w_col32 - 32'd1;

    always_comb begin
        n_stage.sample       = cdig_pkg::t_sample'(i_s_axis_tdata);
        n_stage.row_pos_up   = w_row_up32[cdig_pkg::ROW_POS_W-1:0];
        n_stage.row_pos      = w_row32[cdig_pkg::ROW_POS_W-1:0];
        n_stage.col_pos      = w_col32[cdig_pkg::COL_POS_W-1:0];
        n_stage.col_pos_left = w_col_left32[cdig_pkg::COL_POS_W-1:0];
        n_stage.has_out      = (r_row != '0);
        n_stage.row_second   = (r_row == ROW_W'(1));
        n_stage.row_last     = (r_row == r_row_last);
        n_stage.col_first    = (r_col == '0);
        n_stage.col_second   = (r_col == COL_W'(1));
        n_stage.col_last     = (r_col == r_col_last);
        n_stage.bank         = r_bank;
    end

    // input register and sample history of the current row
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_stage     <= n_stage;
            r_cur_left  <= r_stage.sample;
            r_cur_left2 <= r_cur_left;
            r_prv_left  <= r_stage.bank ? cdig_pkg::t_sample'(w_a_rd_a)
                                        : cdig_pkg::t_sample'(w_b_rd_a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_valid <= 1'b0;
        end else if (w_accept) begin
            r_st_valid <= 1'b1;
        end else if (w_st_done) begin
            r_st_valid <= 1'b0;
        end
    end

    // line stores: bank 0 writes store a, the other store holds the row above
    assign w_col_next_addr = (r_col == r_col_last) ? r_col : r_col + COL_W'(1);

    cdig_ram #(
        .WIDTH (cdig_pkg::SAMPLE_W),
        .DEPTH (MAX_COLS)
    ) u_store_a (
        .i_clk       (i_clk),
        .i_we        (w_accept && !r_bank),
        .i_wr_addr   (r_col),
        .i_wr_data   (i_s_axis_tdata),
        .i_rd_en     (w_accept),
        .i_rd_addr_a (r_col),
        .i_rd_addr_b (w_col_next_addr),
        .o_rd_data_a (w_a_rd_a),
        .o_rd_data_b (w_a_rd_b)
    );

    cdig_ram #(
        .WIDTH (cdig_pkg::SAMPLE_W),
        .DEPTH (MAX_COLS)
    ) u_store_b (
        .i_clk       (i_clk),
        .i_we        (w_accept && r_bank),
        .i_wr_addr   (r_col),
        .i_wr_data   (i_s_axis_tdata),
        .i_rd_en     (w_accept),
        .i_rd_addr_a (r_col),
        .i_rd_addr_b (w_col_next_addr),
        .o_rd_data_a (w_b_rd_a),
        .o_rd_data_b (w_b_rd_b)
    );

    // neighborhood of the staged sample
    always_comb begin
        w_nbr.cur_here  = r_stage.bank ? cdig_pkg::t_sample'(w_b_rd_a)
                                       : cdig_pkg::t_sample'(w_a_rd_a);
        w_nbr.prv_here  = r_stage.bank ? cdig_pkg::t_sample'(w_a_rd_a)
                                       : cdig_pkg::t_sample'(w_b_rd_a);
        w_nbr.prv_next  = r_stage.bank ? cdig_pkg::t_sample'(w_a_rd_b)
                                       : cdig_pkg::t_sample'(w_b_rd_b);
        w_nbr.prv_left  = r_prv_left;
        w_nbr.cur_left  = r_cur_left;
        w_nbr.cur_left2 = r_cur_left2;
    end

    cdig_grad u_grad (
        .i_stage (r_stage),
        .i_nbr   (w_nbr),
        .o_res   (w_res_all)
    );

    // pick the result slot being delivered
    always_comb begin
        case (r_res_sel)
            cdig_pkg::RES_PREV_ROW: w_res = w_res_all[cdig_pkg::RES_PREV_ROW];
            cdig_pkg::RES_LAST_ROW: w_res = w_res_all[cdig_pkg::RES_LAST_ROW];
            cdig_pkg::RES_FINAL:    w_res = w_res_all[cdig_pkg::RES_FINAL];
            default:                w_res = w_res_all[cdig_pkg::RES_PREV_ROW];
        endcase
    end

    // slot sequencer: slots of one sample follow each other in order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_sel <= cdig_pkg::RES_PREV_ROW;
        end else if (w_st_done) begin
            r_res_sel <= cdig_pkg::RES_PREV_ROW;
        end else if (w_issue) begin
            r_res_sel <= r_res_sel + 2'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load_ok) begin
            r_out_valid <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {PAD_W'(0), r_out.col_pos, r_out.row_pos,
                              r_out.grad_inner, r_out.grad_outer};
    assign o_m_axis_tlast  = r_out.last_of_run;
    assign o_m_axis_tuser  = r_out.frame_done;

`ifndef SYNTHESIS
    // a later slot is only selected while a sample is staged
    a_sel_needs_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_sel != cdig_pkg::RES_PREV_ROW |-> r_st_valid)
        else $error("result slot selected with no staged sample");

    // a staged sample is never overwritten before its results are out
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready && r_st_valid |-> w_st_done)
        else $error("staged sample dropped");

    // frame end only on the last result of a run
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.frame_done |-> r_out.last_of_run)
        else $error("frame_done without last_of_run");

    // counters wrap to a fresh frame after the final sample
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && r_col == r_col_last && r_row == r_row_last
        |=> r_row == '0 && r_col == '0 && !r_bank)
        else $error("frame did not restart");

    // column counter stays inside the configured width
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_col_last)
        else $error("column counter beyond row width");
`endif

endmodule

`default_nettype wire

FILE: tb/central_difference_image_gradient_tb.sv
// ----------------------------------------------------------------------------
// central_difference_image_gradient_tb: self-checking bench of the gradient
// Streams rasters of samples through the block under several frame sizes,
// predicts every outer and inner gradient with its position and flags, and
// compares each result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module central_difference_image_gradient_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLS     = 1024;
    localparam int MAX_ROWS     = 4096;
    localparam int FLUSH_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 320;
    localparam int IDLE_PCT     = 8;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic                             i_cfg_index;
    logic [cdig_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                             i_s_axis_tvalid;
    logic                             o_s_axis_tready;
    logic [15:0]                      i_s_axis_tdata;   // sample[15:0]
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready;
    // grad_outer[17:0], grad_inner[35:18], row_pos[47:36], col_pos[57:48], zeros
    logic [cdig_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                             o_m_axis_tlast;   // last_of_run
    logic                             o_m_axis_tuser;   // frame_done

    central_difference_image_gradient #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // gradient predictor state
    logic [cdig_pkg::ROW_COUNT_W-1:0] rows_reg;
    logic [cdig_pkg::COL_COUNT_W-1:0] cols_reg;
    int                               row_ctr;
    int                               col_ctr;
    logic                             bank;
    cdig_pkg::t_sample                line_a [MAX_COLS];
    cdig_pkg::t_sample                line_b [MAX_COLS];
    cdig_pkg::t_result                grad_q [$];

    int   fail_count;
    int   cycle_count;
    int   items_sent;
    logic steady;

    // clock
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, grad_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        i_m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic int rows_eff();
        if (rows_reg < 2) return 2;
        if (rows_reg > MAX_ROWS) return MAX_ROWS;
        return int'(rows_reg);
    endfunction

    function automatic int cols_eff();
        if (cols_reg < 2) return 2;
        if (cols_reg > MAX_COLS) return MAX_COLS;
        return int'(cols_reg);
    endfunction

    // line store of the row being written and of the row before it
    function automatic int cur_rd(int idx);
        return bank ? int'(line_b[idx]) : int'(line_a[idx]);
    endfunction

    function automatic int prv_rd(int idx);
        return bank ? int'(line_a[idx]) : int'(line_b[idx]);
    endfunction

    function automatic cdig_pkg::t_result make_grad(int go, int gi, int r, int c);
        cdig_pkg::t_result res;
        res.grad_outer  = go[cdig_pkg::GRAD_W-1:0];
        res.grad_inner  = gi[cdig_pkg::GRAD_W-1:0];
        res.row_pos     = r[cdig_pkg::ROW_POS_W-1:0];
        res.col_pos     = c[cdig_pkg::COL_POS_W-1:0];
        res.last_of_run = 1'b0;
        res.frame_done  = 1'b0;
        return res;
    endfunction

    // expected results of one accepted sample, then advance the raster position
    task automatic predict_gradients(input cdig_pkg::t_sample s_in);
        int                rows, cols, r, c, s, go, gi, k, n;
        cdig_pkg::t_result run [3];
        rows = rows_eff();
        cols = cols_eff();
        r    = row_ctr;
        c    = col_ctr;
        s    = int'(s_in);
        n    = 0;
        if (c >= cols) c = cols - 1;
        if (r >= 1) begin
            // previous row, same column
            go = (r == 1) ? 2 * (s - prv_rd(c)) : s - cur_rd(c);
            if (c == 0) gi = 2 * (prv_rd(1) - prv_rd(0));
            else if (c == cols - 1) gi = 2 * (prv_rd(c) - prv_rd(c - 1));
            else gi = prv_rd(c + 1) - prv_rd(c - 1);
            run[n] = make_grad(go, gi, r - 1, c);
            n++;
            if (r == rows - 1) begin
                // last row, one column back
                if (c >= 1) begin
                    k  = c - 1;
                    go = 2 * (cur_rd(k) - prv_rd(k));
                    gi = (k == 0) ? 2 * (s - cur_rd(0)) : s - cur_rd(k - 1);
                    run[n] = make_grad(go, gi, r, k);
                    n++;
                end
                // final sample of the frame
                if (c == cols - 1) begin
                    go = 2 * (s - prv_rd(c));
                    gi = 2 * (s - cur_rd(c - 1));
                    run[n] = make_grad(go, gi, r, c);
                    run[n].frame_done = 1'b1;
                    n++;
                end
            end
            run[n - 1].last_of_run = 1'b1;
            for (int i = 0; i < n; i++) grad_q.push_back(run[i]);
        end
        if (bank) line_b[c] = s_in;
        else line_a[c] = s_in;
        if (c + 1 < cols) begin
            col_ctr = c + 1;
        end else begin
            col_ctr = 0;
            if (r + 1 < rows) begin
                row_ctr = r + 1;
                bank    = ~bank;
            end else begin
                row_ctr = 0;
                bank    = 1'b0;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // result checker: a transaction seen here completes at the next rising edge
    always @(negedge i_clk) begin
        cdig_pkg::t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (grad_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h", $time,
                         o_m_axis_tdata);
                fail_count++;
            end else begin
                want = grad_q.pop_front();
                check_field("grad_outer", 64'(unsigned'(want.grad_outer)),
                            64'(o_m_axis_tdata[17:0]));
                check_field("grad_inner", 64'(unsigned'(want.grad_inner)),
                            64'(o_m_axis_tdata[35:18]));
                check_field("row_pos", 64'(want.row_pos), 64'(o_m_axis_tdata[47:36]));
                check_field("col_pos", 64'(want.col_pos), 64'(o_m_axis_tdata[57:48]));
                check_field("tdata padding", '0, 64'(o_m_axis_tdata[63:58]));
                check_field("last_of_run", 64'(want.last_of_run), 64'(o_m_axis_tlast));
                check_field("frame_done", 64'(want.frame_done), 64'(o_m_axis_tuser));
            end
        end
    end

    // one sample transaction; called and returning at a rising edge
    task automatic send_sample(input cdig_pkg::t_sample s);
        logic ok;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s;
        do begin
            @(negedge i_clk);
            ok = o_s_axis_tready;
            @(posedge i_clk);
        end while (!ok);
        predict_gradients(s);
        items_sent++;
    endtask

    // random sample, biased toward the extremes
    function automatic cdig_pkg::t_sample rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return cdig_pkg::t_sample'($urandom);
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) send_sample(rand_sample());
    endtask

    // hold the sender until every expected result is in, then let the pipe settle
    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        while (grad_q.size() != 0) @(posedge i_clk);
        repeat (FLUSH_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [cdig_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx == cdig_pkg::CFG_ROW_COUNT) rows_reg = val[cdig_pkg::ROW_COUNT_W-1:0];
        else cols_reg = val[cdig_pkg::COL_COUNT_W-1:0];
        // any write restarts the frame
        row_ctr = 0;
        col_ctr = 0;
        bank    = 1'b0;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_size(input int rows, input int cols);
        write_reg(cdig_pkg::CFG_ROW_COUNT, rows[cdig_pkg::CFG_DATA_W-1:0]);
        write_reg(cdig_pkg::CFG_COL_COUNT, cols[cdig_pkg::CFG_DATA_W-1:0]);
    endtask

    // 2x2 frame at the reset sizes, full-scale steps
    task automatic test_reset_size();
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        wait_for_results();
    endtask

    // 3x3 frame of mostly alternating extremes for the largest central differences
    task automatic test_extremes();
        cdig_pkg::t_sample pattern [9] = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                                           16'sh0000, 16'sh8000, 16'sh7FFF, 16'shFFFF,
                                           16'sh7FFF};
        set_size(3, 3);
        foreach (pattern[i]) send_sample(pattern[i]);
        wait_for_results();
    endtask

    // sizes below two act as two
    task automatic test_small_sizes();
        set_size(1, 0);
        send_random(4);
        wait_for_results();
    endtask

    // a write in mid frame restarts it, then two frames run back to back
    task automatic test_restart();
        set_size(2, 2);
        send_random(2);
        wait_for_results();
        write_reg(cdig_pkg::CFG_COL_COUNT, cdig_pkg::CFG_DATA_W'(2));
        send_random(8);
        wait_for_results();
    endtask

    // sizes above the maximum clamp; only the start of such frames is streamed
    task automatic test_size_limits();
        set_size(8191, 2);
        send_random(24);
        wait_for_results();
        set_size(2, 2047);
        send_random(24);
        wait_for_results();
    endtask

    // back-to-back frames with neither side idling
    task automatic test_steady_stream();
        set_size(5, 7);
        steady = 1'b1;
        send_random(3 * 35);
        wait_for_results();
        steady = 1'b0;
    endtask

    // random sizes, mostly whole frames, some cut short by a new setting
    task automatic test_random_frames();
        int start, rows, cols, frames, cut;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: rows = $urandom_range(0, 1);
                1: rows = $urandom_range(7, 16);
                default: rows = $urandom_range(2, 6);
            endcase
            case ($urandom_range(0, 9))
                0: cols = $urandom_range(0, 1);
                1: cols = $urandom_range(13, 64);
                default: cols = $urandom_range(2, 12);
            endcase
            set_size(rows, cols);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                if ($urandom_range(0, 5) == 0) begin
                    cut = $urandom_range(1, rows_eff() * cols_eff() - 1);
                    send_random(cut);
                    break;
                end
                send_random(rows_eff() * cols_eff());
            end
            wait_for_results();
        end
    endtask

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = cdig_pkg::CFG_ROW_COUNT;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b1;
        fail_count      = 0;
        cycle_count     = 0;
        items_sent      = 0;
        steady          = 1'b0;
        rows_reg        = 2;
        cols_reg        = 2;
        row_ctr         = 0;
        col_ctr         = 0;
        bank            = 1'b0;
        for (int i = 0; i < MAX_COLS; i++) begin
            line_a[i] = '0;
            line_b[i] = '0;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_size();
        test_extremes();
        test_small_sizes();
        test_restart();
        test_size_limits();
        test_steady_stream();
        test_random_frames();
        wait_for_results();

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: files.f
design/cdig_pkg.sv
design/cdig_ram.sv
design/cdig_grad.sv
design/central_difference_image_gradient.sv
tb/central_difference_image_gradient_tb.sv
